FILE: rtl/bxf_pkg.sv
// Package for the 3x3 box (mean) filter: widths, register indexes and the
// divide-by-nine constants, plus the line buffer write request type.
// No dependencies.
package bxf_pkg;

    localparam int PIX_W      = 16;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = PIX_W + 4;

    // floor(x / 9) = (x * DIV9_MUL) >> DIV9_SHIFT for every x below 2**SUM_W
    localparam int DIV9_SHIFT = SUM_W + 3;
    localparam int DIV9_MUL_W = SUM_W;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL =
        DIV9_MUL_W'(((64'd1 << DIV9_SHIFT) + 64'd8) / 64'd9);
    localparam int PROD_W     = SUM_W + DIV9_MUL_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(MAX_HEIGHT);
    localparam logic [CFG_W-1:0] DIM_MIN          = CFG_W'(3);

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] data_a;   // new pixel, goes to the previous-row store
        logic [PIX_W-1:0] data_b;   // old previous row, moves to the older store
    } lb_wr_t;

endpackage

FILE: rtl/box_filter_3x3_mean_unit.sv
// 3x3 box filter: one pixel per cycle in raster order, result for the centre
// (r-1,c-1) once r,c >= 2; an item passes through stage 1, stage 2 and the output register.
// Throughput: one item per cycle unless the output stalls; line stores are read at
// acceptance and written back at a different column, so no interlock applies.
// Reset (aresetn, synchronous): counters, window and valids cleared, width and
// height back to 1024; line store contents are left as they are.
module box_filter_3x3_mean_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bxf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bxf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [15:0]                   s_pixel_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [15:0]                   m_mean_value,
    output logic [9:0]                    m_out_row,
    output logic [9:0]                    m_out_col,
    output logic                          m_frame_done
);

    localparam int PIX_W = bxf_pkg::PIX_W;
    localparam int COL_W = bxf_pkg::COL_W;
    localparam int ROW_W = bxf_pkg::ROW_W;
    localparam int CFG_W = bxf_pkg::CFG_W;
    localparam int SUM_W = bxf_pkg::SUM_W;

    // configuration
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;

    // stage 0 counters
    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [CFG_W-1:0] col_inc;
    logic [CFG_W-1:0] row_inc;
    logic             emit0;
    logic             done0;

    // stage 1: read data back, sum
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_done_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [PIX_W-1:0] win_reg [6];
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [SUM_W-1:0] sum;

    // stage 2: divide by nine
    logic             s2_valid_reg;
    logic             s2_done_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic [bxf_pkg::PROD_W-1:0] prod;

    // output register
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_mean_reg;
    logic [ROW_W-1:0] m_row_reg;
    logic [COL_W-1:0] m_col_reg;
    logic             m_done_reg;

    logic out_free, s2_free, s2_move, s1_move, accept;
    bxf_pkg::lb_wr_t lb_wr;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= bxf_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bxf_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                bxf_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                bxf_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg < bxf_pkg::DIM_MIN)
            w_eff = bxf_pkg::DIM_MIN;
        else if (frame_width_reg > CFG_W'(bxf_pkg::MAX_WIDTH))
            w_eff = CFG_W'(bxf_pkg::MAX_WIDTH);
        else
            w_eff = frame_width_reg;
        if (frame_height_reg < bxf_pkg::DIM_MIN)
            h_eff = bxf_pkg::DIM_MIN;
        else if (frame_height_reg > CFG_W'(bxf_pkg::MAX_HEIGHT))
            h_eff = CFG_W'(bxf_pkg::MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    // ---------------- flow control ----------------
    assign out_free = !m_valid_reg || m_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s2_move  = s2_valid_reg && out_free;
    // border items only write the line stores, they never wait for stage 2
    assign s1_move  = s1_valid_reg && (!s1_emit_reg || s2_free);
    assign s_ready  = !s1_valid_reg || s1_move;
    assign accept   = s_valid && s_ready;

    // ---------------- stage 0 ----------------
    assign col_inc = CFG_W'(col_count_reg) + CFG_W'(1);
    assign row_inc = CFG_W'(row_count_reg) + CFG_W'(1);
    assign emit0   = (row_count_reg >= ROW_W'(2)) && (col_count_reg >= COL_W'(2));
    assign done0   = (row_inc == h_eff) && (col_inc == w_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (accept) begin
            if (col_inc >= w_eff) begin
                col_count_reg <= '0;
                row_count_reg <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_count_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_emit_reg <= emit0;
            s1_done_reg <= done0;
            s1_pix_reg  <= s_pixel_in[PIX_W-1:0];
            s1_col_reg  <= col_count_reg;
            s1_row_reg  <= row_count_reg;
        end
    end

    // ---------------- line stores ----------------
    always_comb begin
        lb_wr.en     = s1_move;
        lb_wr.addr   = s1_col_reg;
        lb_wr.data_a = s1_pix_reg;
        lb_wr.data_b = mid;
    end

    bxf_line_buf u_line_buf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .wr      (lb_wr),
        .rd_a    (mid),
        .rd_b    (top)
    );

    // ---------------- stage 1: window and sum ----------------
    always_comb begin
        sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(s1_pix_reg);
        for (int k = 0; k < 6; k++) begin
            sum = sum + SUM_W'(win_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 6; k++) begin
                win_reg[k] <= '0;
            end
        end else if (s1_move) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= s1_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_move && s1_emit_reg) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_move) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move && s1_emit_reg) begin
            s2_sum_reg  <= sum;
            s2_done_reg <= s1_done_reg;
            s2_col_reg  <= s1_col_reg - COL_W'(1);
            s2_row_reg  <= s1_row_reg - ROW_W'(1);
        end
    end

    // ---------------- stage 2: divide by nine ----------------
    assign prod = bxf_pkg::PROD_W'(s2_sum_reg) * bxf_pkg::PROD_W'(bxf_pkg::DIV9_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_move) begin
            m_mean_reg <= prod[bxf_pkg::DIV9_SHIFT +: PIX_W];
            m_row_reg  <= s2_row_reg;
            m_col_reg  <= s2_col_reg;
            m_done_reg <= s2_done_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mean_value = m_mean_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_frame_done = m_done_reg;

endmodule

FILE: rtl/bxf_line_buf.sv
// Two line stores for the 3x3 box filter: previous row (a) and the row
// before it (b). Registered reads, one write port each. Uses bxf_pkg.
module bxf_line_buf (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [bxf_pkg::COL_W-1:0]  rd_addr,
    input  bxf_pkg::lb_wr_t            wr,
    output logic [bxf_pkg::PIX_W-1:0]  rd_a,
    output logic [bxf_pkg::PIX_W-1:0]  rd_b
);

    logic [bxf_pkg::PIX_W-1:0] mem_a [bxf_pkg::MAX_WIDTH];
    logic [bxf_pkg::PIX_W-1:0] mem_b [bxf_pkg::MAX_WIDTH];
    logic [bxf_pkg::PIX_W-1:0] rd_a_reg;
    logic [bxf_pkg::PIX_W-1:0] rd_b_reg;

    // read data holds while the item waits in the next stage
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem_a[rd_addr];
            rd_b_reg <= mem_b[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_a[wr.addr] <= wr.data_a;
            mem_b[wr.addr] <= wr.data_b;
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

FILE: verif/box_filter_3x3_mean_checker.sv
`timescale 1ns / 1ps
// Scoreboard for box_filter_3x3_mean_unit: follows the register, pixel and result
// channels, predicts every filtered pixel and compares it with the block's output.
// Depends on bxf_pkg.
module box_filter_3x3_mean_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bxf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bxf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [15:0]                   s_pixel_in,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [15:0]                   m_mean_value,
    input  logic [9:0]                    m_out_row,
    input  logic [9:0]                    m_out_col,
    input  logic                          m_frame_done,
    output int                            fail_count,
    output int                            pending
);
    import bxf_pkg::*;

    typedef struct packed {
        logic [15:0] mean;
        logic [9:0]  row;
        logic [9:0]  col;
        logic        done;
    } filtered_px_t;

    filtered_px_t     mean_q[$];
    logic [15:0]      prev_row [MAX_WIDTH];
    logic [15:0]      older_row [MAX_WIDTH];
    logic [15:0]      win [6];
    int               col_pos;
    int               row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int               errors;

    initial begin
        foreach (prev_row[i]) begin
            prev_row[i]  = '0;
            older_row[i] = '0;
        end
        errors = 0;
    end

    function automatic int clamp_dim(input logic [CFG_W-1:0] raw, input int hi);
        if (raw < DIM_MIN)
            return DIM_MIN;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    task automatic filter_pixel(input logic [15:0] px);
        int           w;
        int           h;
        int           c;
        int           r;
        int           acc;
        logic [15:0]  top;
        logic [15:0]  mid;
        filtered_px_t res;
        w   = clamp_dim(width_reg, MAX_WIDTH);
        h   = clamp_dim(height_reg, MAX_HEIGHT);
        c   = col_pos % MAX_WIDTH;
        r   = row_pos;
        top = older_row[c];
        mid = prev_row[c];
        if (r >= 2 && c >= 2) begin
            acc = top + mid + px;
            for (int k = 0; k < 6; k++)
                acc += win[k];
            res.mean = 16'(acc / 9);
            res.row  = 10'(r - 1);
            res.col  = 10'(c - 1);
            res.done = (r + 1 == h) && (c + 1 == w);
            mean_q.push_back(res);
        end
        older_row[c] = mid;
        prev_row[c]  = px;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = px;
        // wrap compares against the current sizes, so a shrink mid-frame wraps at once
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_result();
        filtered_px_t got;
        filtered_px_t want;
        got = {m_mean_value, m_out_row, m_out_col, m_frame_done};
        if (mean_q.size() == 0) begin
            if (errors < 10)
                $display("unexpected item: mean %0d row %0d col %0d done %0b",
                         got.mean, got.row, got.col, got.done);
            errors++;
        end else begin
            want = mean_q.pop_front();
            if (got.mean !== want.mean || got.row !== want.row ||
                got.col !== want.col || got.done !== want.done) begin
                if (errors < 10)
                    $display("mismatch: expected mean %0d row %0d col %0d done %0b, got mean %0d row %0d col %0d done %0b",
                             want.mean, want.row, want.col, want.done,
                             got.mean, got.row, got.col, got.done);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            foreach (win[k])
                win[k] = '0;
            mean_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_FRAME_HEIGHT)
                    height_reg = cfg_data;
            end
            // a result can never come from the pixel taken at the same edge
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready)
                filter_pixel(s_pixel_in);
        end
        fail_count <= errors;
        pending    <= mean_q.size();
    end

endmodule

FILE: verif/tb_box_filter_3x3_mean_unit.sv
`timescale 1ns / 1ps
// Top of the box_filter_3x3_mean_unit testbench: register writes and pixel frames
// under several idling patterns, verdict at the end. Checking is done by
// box_filter_3x3_mean_checker. Depends on bxf_pkg.
module tb_box_filter_3x3_mean_unit;
    import bxf_pkg::*;

    localparam int RUN_LIMIT     = 500_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MODE_ITEMS    = 80;
    localparam int OVERSIZE_PX   = 20;

    // indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    localparam logic [15:0] CORNER_PX [9] = '{
        16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001,
        16'h8000, 16'hFFFE, 16'h7FFF, 16'h0000
    };

    logic                 aclk;
    logic                 aresetn    = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 s_valid    = 1'b0;
    logic                 s_ready;
    logic [15:0]          s_pixel_in = '0;
    logic                 m_valid;
    logic                 m_ready    = 1'b0;
    logic [15:0]          m_mean_value;
    logic [9:0]           m_out_row;
    logic [9:0]           m_out_col;
    logic                 m_frame_done;

    int fail_count;
    int pending;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int sent;
    int cycle_count;

    box_filter_3x3_mean_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mean_value (m_mean_value),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_done (m_frame_done)
    );

    box_filter_3x3_mean_checker u_mean_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mean_value (m_mean_value),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_done (m_frame_done),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial begin
        for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int frame_dim(input logic [CFG_W-1:0] raw, input int hi);
        if (raw < DIM_MIN)
            return DIM_MIN;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(15));
            3: return 16'hFFFF - 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    // valid stays high across back-to-back items; it drops only for idle cycles and in settle()
    task automatic push_pixel(input logic [15:0] px);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= px;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        write_reg(REG_FRAME_WIDTH, w_raw);
        write_reg(REG_FRAME_HEIGHT, h_raw);
        if ($urandom_range(7) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // wait for every expected item, then let pixels that give no result leave the pipe
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_frame(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        int n;
        n = frame_dim(w_raw, MAX_WIDTH) * frame_dim(h_raw, MAX_HEIGHT);
        settle();
        set_frame(w_raw, h_raw);
        repeat (n) push_pixel(rand_pixel());
    endtask

    // sizes change part way through a frame; the width never grows, since columns
    // beyond the old width hold nothing for the rows above
    task automatic run_split_frame();
        int               w0;
        int               h0;
        int               w1;
        int               h1;
        int               done_px;
        int               c;
        int               r;
        int               rest;
        logic [CFG_W-1:0] w1_raw;
        logic [CFG_W-1:0] h1_raw;
        w0 = $urandom_range(4, 20);
        h0 = $urandom_range(3, 10);
        settle();
        set_frame(CFG_W'(w0), CFG_W'(h0));
        done_px = $urandom_range(1, w0 * h0 - 1);
        repeat (done_px) push_pixel(rand_pixel());
        c      = done_px % w0;
        r      = done_px / w0;
        w1_raw = CFG_W'($urandom_range(0, w0));
        h1_raw = CFG_W'($urandom_range(0, 12));
        w1     = frame_dim(w1_raw, MAX_WIDTH);
        h1     = frame_dim(h1_raw, MAX_HEIGHT);
        rest   = ((c + 1 >= w1) ? 1 : w1 - c) + ((r + 1 >= h1) ? 0 : (h1 - r - 1) * w1);
        settle();
        set_frame(w1_raw, h1_raw);
        repeat (rest) push_pixel(rand_pixel());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest frame at full scale
        set_frame(CFG_W'(3), CFG_W'(3));
        repeat (9) push_pixel(16'hFFFF);

        // sizes below range clamp to 3; undecoded indexes must leave them alone
        settle();
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        cfg_valid <= 1'b0;
        foreach (CORNER_PX[i])
            push_pixel(CORNER_PX[i]);

        for (int mode = 0; mode < 4; mode++) begin
            settle();
            case (mode)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct <= 0;
                end
                1: begin
                    src_idle_pct  = 86;
                    snk_stall_pct <= 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct <= 86;
                end
                default: begin
                    src_idle_pct  = 19;
                    snk_stall_pct <= 19;
                end
            endcase
            if (mode == 0) begin
                // oversize registers clamp to 1024: the start of row 0 must not wrap,
                // then the frame is finished at a small width
                settle();
                set_frame('1, CFG_W'(1200));
                repeat (OVERSIZE_PX) push_pixel(rand_pixel());
                settle();
                set_frame(CFG_W'(OVERSIZE_PX), CFG_W'(3));
                repeat (2 * OVERSIZE_PX + 1) push_pixel(rand_pixel());
            end
            sent = 0;
            while (sent < MODE_ITEMS) begin
                if ($urandom_range(3) == 0)
                    run_split_frame();
                else
                    run_frame(CFG_W'($urandom_range(0, 24)), CFG_W'($urandom_range(0, 10)));
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bxf_pkg.sv
rtl/bxf_line_buf.sv
rtl/box_filter_3x3_mean_unit.sv
verif/box_filter_3x3_mean_checker.sv
verif/tb_box_filter_3x3_mean_unit.sv
